// ===== hw/rtl/aier_pkg.sv =====
// Package for the ARP / ICMP echo responder: sizes, codes, state type and
// constant reply header tables. No dependencies.
package aier_pkg;

	localparam int HdrLen   = 42;
	localparam int CountMax = 64;
	localparam int ReplyLen = 42;

	localparam logic [6:0]  HDR_LEN_C   = 7'(HdrLen);
	localparam logic [6:0]  COUNT_MAX_C = 7'(CountMax);
	localparam logic [5:0]  LAST_IDX_C  = 6'(ReplyLen - 1);
	localparam logic [15:0] IP_SUM_INIT = 16'h851D; // 0x4500 + 0x001C + 0x4001

	localparam logic [7:0] ETH_TYPE_HI = 8'h08;
	localparam logic [7:0] ETH_ARP_LO  = 8'h06;
	localparam logic [7:0] ETH_IP_LO   = 8'h00;
	localparam logic [7:0] IP_VER_IHL  = 8'h45;
	localparam logic [7:0] IP_PROTO_IC = 8'h01;
	localparam logic [7:0] ICMP_ECHO   = 8'h08;

	typedef enum logic {
		KIND_ARP  = 1'b0,
		KIND_ICMP = 1'b1
	} kind_t;

	typedef enum logic [0:0] {
		REG_LOCAL_IP  = 1'b0,
		REG_LOCAL_MAC = 1'b1
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CHK  = 5'b00010,
		ST_RD   = 5'b00100,
		ST_LOAD = 5'b01000,
		ST_SEND = 5'b10000
	} state_t;

	// fixed bytes of the ARP reply, positions 12..21
	function automatic logic [7:0] arp_hdr_byte(input logic [5:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (idx)
			6'd12: b = 8'h08;
			6'd13: b = 8'h06;
			6'd15: b = 8'h01;
			6'd16: b = 8'h08;
			6'd18: b = 8'h06;
			6'd19: b = 8'h04;
			6'd21: b = 8'h02;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// fixed bytes of the echo reply, positions 12..23 and 34..35
	function automatic logic [7:0] icmp_hdr_byte(input logic [5:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (idx)
			6'd12: b = 8'h08;
			6'd14: b = 8'h45;
			6'd17: b = 8'h1C;
			6'd22: b = 8'h40;
			6'd23: b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/arp_icmp_echo_responder_unit.sv =====
// ARP / ICMP echo responder top level: header capture memory, checksum adder,
// reply sequencer. Depends on aier_pkg.
//
// Usage: received frame bytes enter on s_axis (tdata = byte, tlast = end of
// frame), one transaction per cycle while s_axis_tready is high. The first 42
// bytes of each frame go into a header memory; a single 16-bit end-around-carry
// adder folds the IP address words and ICMP words into two checksum sums as
// bytes arrive. In the cycle after the last byte, the frame is checked. An ARP
// frame whose target IP is local_ip or an IPv4 ICMP echo request yields a
// 42-byte reply on m_axis (tdata = byte, tlast on byte 42, tuser = 0 ARP /
// 1 ICMP); other frames and frames under 42 bytes yield nothing.
// Each reply byte passes through memory read, byte select and send; the send
// waits while the receiver holds m_axis_tready low. s_axis_tready stays low
// from the last input byte until the final reply transaction, so a replied
// frame blocks input until its reply ends, an unreplied frame only during
// the check. Reset: local_ip = 192.168.156.127, local_mac = 0, byte count 0,
// idle. cfg_we writes local_ip (cfg_index 0) or local_mac (cfg_index 1); the
// user must do so only while idle, which the block itself does not enforce.
module arp_icmp_echo_responder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] tx_byte
	output logic        m_axis_tlast,
	output logic        m_axis_tuser,  // [0] reply_kind
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data
);
	import aier_pkg::*;

	state_t      st_q;
	logic [6:0]  cnt_q;
	logic [31:0] local_ip_q;
	logic [47:0] local_mac_q;
	logic        len_ok_q;
	kind_t       kind_q;
	logic [5:0]  idx_q;

	logic [7:0]  hdr_mem [HdrLen];
	logic [7:0]  rd_data_q;
	logic [5:0]  rd_addr;

	logic        e12_q, arp_q, ipt_q, v45_q, p1_q, t8_q;
	logic [31:0] tip_q;
	logic [7:0]  prev_q;
	logic [15:0] ip_acc_q, icmp_acc_q;

	logic [7:0]  tx_data_q;
	logic        tx_last_q;
	logic [7:0]  tx_byte_d;

	logic        rx_fire, tx_fire, mem_we;
	logic [5:0]  pos;
	logic        add_en, add_icmp;
	logic [15:0] add_a, add_b, add_res;
	logic [16:0] add_raw;
	logic        do_arp, do_icmp;
	logic [2:0]  mac_j, mac_sh;
	logic [7:0]  mac_byte;
	logic [15:0] ip_cs, icmp_cs;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = (st_q == ST_SEND);
	assign m_axis_tdata  = tx_data_q;
	assign m_axis_tlast  = tx_last_q;
	assign m_axis_tuser  = kind_q;

	assign rx_fire = s_axis_tvalid && s_axis_tready;
	assign tx_fire = m_axis_tvalid && m_axis_tready;
	assign pos     = cnt_q[5:0];
	assign mem_we  = rx_fire && (cnt_q < HDR_LEN_C);

	// shared ones-complement adder
	always_comb begin
		add_en   = 1'b0;
		add_icmp = 1'b0;
		add_a    = 16'h0000;
		if (rx_fire && !cnt_q[6]) begin
			case (pos)
				6'd27: begin
					add_en = 1'b1;
					add_a  = IP_SUM_INIT;
				end
				6'd29, 6'd31, 6'd33: begin
					add_en = 1'b1;
					add_a  = ip_acc_q;
				end
				6'd39: begin
					add_en   = 1'b1;
					add_icmp = 1'b1;
				end
				6'd41: begin
					add_en   = 1'b1;
					add_icmp = 1'b1;
					add_a    = icmp_acc_q;
				end
				default: add_en = 1'b0;
			endcase
		end
	end

	assign add_b   = {prev_q, s_axis_tdata};
	assign add_raw = {1'b0, add_a} + {1'b0, add_b};
	assign add_res = add_raw[15:0] + {15'd0, add_raw[16]};

	assign do_arp  = len_ok_q && e12_q && arp_q && (tip_q == local_ip_q);
	assign do_icmp = len_ok_q && e12_q && ipt_q && v45_q && p1_q && t8_q;

	assign ip_cs   = ~ip_acc_q;
	assign icmp_cs = ~icmp_acc_q;

	// reply byte source selection
	always_comb begin
		rd_addr   = 6'd0;
		tx_byte_d = 8'h00;
		mac_j     = 3'd0;
		if (kind_q == KIND_ARP) begin
			if (idx_q < 6'd6) begin
				rd_addr   = idx_q + 6'd22;
				tx_byte_d = rd_data_q;
			end else if (idx_q < 6'd12) begin
				mac_j     = 3'(idx_q - 6'd6);
				tx_byte_d = mac_byte;
			end else if (idx_q < 6'd22) begin
				tx_byte_d = arp_hdr_byte(idx_q);
			end else if (idx_q < 6'd28) begin
				mac_j     = 3'(idx_q - 6'd22);
				tx_byte_d = mac_byte;
			end else if (idx_q < 6'd32) begin
				rd_addr   = idx_q + 6'd10;
				tx_byte_d = rd_data_q;
			end else begin
				rd_addr   = idx_q - 6'd10;
				tx_byte_d = rd_data_q;
			end
		end else begin
			if (idx_q < 6'd6) begin
				rd_addr   = idx_q + 6'd6;
				tx_byte_d = rd_data_q;
			end else if (idx_q < 6'd12) begin
				mac_j     = 3'(idx_q - 6'd6);
				tx_byte_d = mac_byte;
			end else if (idx_q == 6'd24) begin
				tx_byte_d = ip_cs[15:8];
			end else if (idx_q == 6'd25) begin
				tx_byte_d = ip_cs[7:0];
			end else if (idx_q == 6'd36) begin
				tx_byte_d = icmp_cs[15:8];
			end else if (idx_q == 6'd37) begin
				tx_byte_d = icmp_cs[7:0];
			end else if (idx_q >= 6'd26 && idx_q < 6'd30) begin
				rd_addr   = idx_q + 6'd4;
				tx_byte_d = rd_data_q;
			end else if (idx_q >= 6'd30 && idx_q < 6'd34) begin
				rd_addr   = idx_q - 6'd4;
				tx_byte_d = rd_data_q;
			end else if (idx_q >= 6'd38) begin
				rd_addr   = idx_q;
				tx_byte_d = rd_data_q;
			end else begin
				tx_byte_d = icmp_hdr_byte(idx_q);
			end
		end
	end

	assign mac_sh   = 3'd5 - mac_j;
	assign mac_byte = 8'(local_mac_q >> {mac_sh, 3'b000});

	// header memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hdr_mem[pos] <= s_axis_tdata;
		end
		if (st_q == ST_RD) begin
			rd_data_q <= hdr_mem[rd_addr];
		end
	end

	// field capture, checksum sums and reply byte register
	always_ff @(posedge clk) begin
		if (rx_fire) begin
			prev_q <= s_axis_tdata;
			if (!cnt_q[6]) begin
				case (pos)
					6'd12: e12_q <= (s_axis_tdata == ETH_TYPE_HI);
					6'd13: begin
						arp_q <= (s_axis_tdata == ETH_ARP_LO);
						ipt_q <= (s_axis_tdata == ETH_IP_LO);
					end
					6'd14: v45_q <= (s_axis_tdata == IP_VER_IHL);
					6'd23: p1_q  <= (s_axis_tdata == IP_PROTO_IC);
					6'd34: t8_q  <= (s_axis_tdata == ICMP_ECHO);
					6'd38, 6'd39, 6'd40, 6'd41: tip_q <= {tip_q[23:0], s_axis_tdata};
					default: ;
				endcase
			end
		end
		if (add_en) begin
			if (add_icmp) begin
				icmp_acc_q <= add_res;
			end else begin
				ip_acc_q <= add_res;
			end
		end
		if (st_q == ST_LOAD) begin
			tx_data_q <= tx_byte_d;
			tx_last_q <= (idx_q == LAST_IDX_C);
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q  <= 32'hC0A8_9C7F;
			local_mac_q <= 48'h0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LOCAL_IP:  local_ip_q  <= cfg_data[31:0];
				REG_LOCAL_MAC: local_mac_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cnt_q    <= 7'd0;
			len_ok_q <= 1'b0;
			kind_q   <= KIND_ARP;
			idx_q    <= 6'd0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (rx_fire) begin
						if (s_axis_tlast) begin
							len_ok_q <= (cnt_q >= HDR_LEN_C - 7'd1);
							cnt_q    <= 7'd0;
							st_q     <= ST_CHK;
						end else if (cnt_q != COUNT_MAX_C) begin
							cnt_q <= cnt_q + 7'd1;
						end
					end
				end
				ST_CHK: begin
					idx_q <= 6'd0;
					if (do_arp) begin
						kind_q <= KIND_ARP;
						st_q   <= ST_RD;
					end else if (do_icmp) begin
						kind_q <= KIND_ICMP;
						st_q   <= ST_RD;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_RD: st_q <= ST_LOAD;
				ST_LOAD: st_q <= ST_SEND;
				ST_SEND: begin
					if (tx_fire) begin
						if (tx_last_q) begin
							st_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 6'd1;
							st_q  <= ST_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/aier_checker.sv =====
// Port-level checker for arp_icmp_echo_responder_unit, bound to the top level.
// Depends only on the top level's ports.
module aier_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast,
	input logic       m_axis_tuser
);

	// no input taken while a reply is in flight
	a_no_rx_during_tx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while reply byte pending");

	// frame end is always followed by the check state: no input ready, no reply valid
	a_check_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready && !m_axis_tvalid)
		else $error("no check cycle after frame end");

	// stalled reply byte holds
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("reply byte changed under stall");

	// mid-reply: input stays blocked and kind holds for the next byte
	a_mid_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
		!m_axis_tvalid && !s_axis_tready && $stable(m_axis_tuser))
		else $error("reply broken off before its last byte");

endmodule

bind arp_icmp_echo_responder_unit aier_checker u_aier_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
